// ===== rtl/regex_dot_star_matcher_assert.svh =====
// ---------------------------------------------------------------------------
// regex_dot_star_matcher_assert.svh
// Assertion macros for the pattern matcher; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef REGEX_DOT_STAR_MATCHER_ASSERT_SVH
`define REGEX_DOT_STAR_MATCHER_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, off while reset is asserted.
`define RDSM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("rdsm assertion failed");
// Clocked check that also holds during reset.
`define RDSM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("rdsm assertion failed");
`else
`define RDSM_ASSERT(lbl, clk, rstn, prop)
`define RDSM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/rdsm_pkg.sv =====
// ---------------------------------------------------------------------------
// rdsm_pkg
// Shared types and constants of the pattern matcher.
// ---------------------------------------------------------------------------
package rdsm_pkg;

  localparam int TokenLimit = 32;
  localparam int CountW     = 6;
  localparam int DataW      = 64;
  localparam int RegIdxW    = 3;

  localparam logic KindByte    = 1'b0;
  localparam logic KindRestart = 1'b1;

  typedef enum logic [RegIdxW-1:0] {
    RegTokenBytes0 = 3'd0,
    RegTokenBytes1 = 3'd1,
    RegTokenBytes2 = 3'd2,
    RegTokenBytes3 = 3'd3,
    RegDotMask     = 3'd4,
    RegStarMask    = 3'd5,
    RegTokenCount  = 3'd6
  } rdsm_reg_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] text_byte;
  } rdsm_in_t;

  typedef struct packed {
    logic matched;
    logic alive;
  } rdsm_out_t;

  typedef struct packed {
    logic [3:0][DataW-1:0]  token_bytes;
    logic [TokenLimit-1:0]  dot_mask;
    logic [TokenLimit-1:0]  star_mask;
    logic [CountW-1:0]      token_count;
  } rdsm_cfg_t;

endpackage

// ===== rtl/rdsm_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// rdsm_cfg_regs
// Pattern register file: token bytes, dot/star masks and token count.
// ---------------------------------------------------------------------------
module rdsm_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [rdsm_pkg::RegIdxW-1:0]      wr_index_i,
  input  logic [rdsm_pkg::DataW-1:0]        wr_data_i,
  output rdsm_pkg::rdsm_cfg_t               cfg_o
);

  rdsm_pkg::rdsm_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (rdsm_pkg::rdsm_reg_e'(wr_index_i))
        rdsm_pkg::RegTokenBytes0: cfg_d.token_bytes[0] = wr_data_i;
        rdsm_pkg::RegTokenBytes1: cfg_d.token_bytes[1] = wr_data_i;
        rdsm_pkg::RegTokenBytes2: cfg_d.token_bytes[2] = wr_data_i;
        rdsm_pkg::RegTokenBytes3: cfg_d.token_bytes[3] = wr_data_i;
        rdsm_pkg::RegDotMask:
          cfg_d.dot_mask = wr_data_i[rdsm_pkg::TokenLimit-1:0];
        rdsm_pkg::RegStarMask:
          cfg_d.star_mask = wr_data_i[rdsm_pkg::TokenLimit-1:0];
        rdsm_pkg::RegTokenCount:
          cfg_d.token_count = wr_data_i[rdsm_pkg::CountW-1:0];
        default: ; // unmapped index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/rdsm_nfa_step.sv =====
// ---------------------------------------------------------------------------
// rdsm_nfa_step
// One NFA update: byte advance or restart, then star closure.
// ---------------------------------------------------------------------------
module rdsm_nfa_step #(
  parameter int MAX_TOKENS = rdsm_pkg::TokenLimit
) (
  input  rdsm_pkg::rdsm_cfg_t      cfg_i,
  input  rdsm_pkg::rdsm_in_t       item_i,
  input  logic [MAX_TOKENS:0]      active_i,
  output logic [MAX_TOKENS:0]      active_o,
  output rdsm_pkg::rdsm_out_t      result_o
);

  localparam int P      = MAX_TOKENS + 1;
  localparam int CntW   = $clog2(P);
  localparam int Levels = $clog2(P);

  logic [CntW-1:0]       n;
  logic [P-1:0]          pos_mask;
  logic [MAX_TOKENS-1:0] tok_mask;
  logic [P-1:0]          cur;
  logic [MAX_TOKENS-1:0] hit;
  logic [P-1:0]          step_set;
  logic [P-1:0]          seed;
  logic [P-1:0]          link;
  logic [P-1:0]          closed;

  // saturate count
  always_comb begin
    if (cfg_i.token_count > rdsm_pkg::CountW'(MAX_TOKENS)) begin
      n = CntW'(MAX_TOKENS);
    end else begin
      n = cfg_i.token_count[CntW-1:0];
    end
  end

  always_comb begin
    for (int k = 0; k < P; k++) begin
      pos_mask[k] = (CntW'(k) <= n);
    end
    for (int k = 0; k < MAX_TOKENS; k++) begin
      tok_mask[k] = (CntW'(k) < n);
    end
  end

  assign cur = active_i & pos_mask;

  always_comb begin
    logic [7:0] tb;
    tb = '0;
    for (int k = 0; k < MAX_TOKENS; k++) begin
      tb     = cfg_i.token_bytes[k/8][8*(k%8) +: 8];
      hit[k] = cur[k] & tok_mask[k] & (cfg_i.dot_mask[k] | (tb == item_i.text_byte));
    end
  end

  // star token stays put, plain token moves one position on
  always_comb begin
    step_set = '0;
    for (int k = 0; k < MAX_TOKENS; k++) begin
      step_set[k]   = step_set[k]   | (hit[k] &  cfg_i.star_mask[k]);
      step_set[k+1] = step_set[k+1] | (hit[k] & ~cfg_i.star_mask[k]);
    end
  end

  assign seed = (item_i.kind == rdsm_pkg::KindRestart) ? P'(1) : step_set;

  // link[k]: position k-1 being active activates k (token k-1 is a star)
  always_comb begin
    link[0] = 1'b0;
    for (int k = 1; k < P; k++) begin
      link[k] = cfg_i.star_mask[k-1];
    end
  end

  // closure as a parallel prefix, log2 levels like a carry-lookahead
  always_comb begin
    logic [P-1:0] g;
    logic [P-1:0] pp;
    g  = seed;
    pp = link;
    for (int lvl = 0; lvl < Levels; lvl++) begin
      g  = g  | (pp & (g  << (1 << lvl)));
      pp = pp & (pp << (1 << lvl));
    end
    closed = g & pos_mask;
  end

  assign active_o         = closed;
  assign result_o.matched = closed[n];
  assign result_o.alive   = |closed;

endmodule

// ===== rtl/regex_dot_star_matcher.sv =====
// ---------------------------------------------------------------------------
// regex_dot_star_matcher
// Whole-text matcher for literal / '.' / 'x*' patterns, bit-parallel NFA.
// ---------------------------------------------------------------------------
// Usage:
//  - Config channel (cfg_valid_i/cfg_ready_o, index + 64-bit data) loads the
//    pattern: token bytes 0..3, dot mask, star mask, token count. Ready is
//    always high. Write only while idle, then send a restart request.
//  - Input channel (in_valid_i/in_stall_o): kind = restart or text byte.
//    A restart reloads position zero and reports whether the empty text
//    matches; a byte advances the active set by one byte.
//  - Output channel (out_valid_o/out_stall_i): one result per request,
//    matched (whole pattern consumed) and alive (any position active).
//  - A request goes through the input register, then the result register;
//    one request per cycle while out_stall_i is low. The rate is set by the
//    combinational NFA update from input register to active-position register.
//  - A stalled output holds; one more request can still sit in the input
//    register, and in_stall_o rises only once both stages are full.
//  - Reset clears the pattern and leaves only position zero active.
// ---------------------------------------------------------------------------
`include "regex_dot_star_matcher_assert.svh"

module regex_dot_star_matcher #(
  parameter int MAX_TOKENS = rdsm_pkg::TokenLimit
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rdsm_pkg::RegIdxW-1:0]  cfg_index_i,
  input  logic [rdsm_pkg::DataW-1:0]    cfg_data_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rdsm_pkg::rdsm_in_t            in_data_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rdsm_pkg::rdsm_out_t           out_data_o
);

  rdsm_pkg::rdsm_cfg_t cfg;

  // input register stage
  logic                s1_valid_q, s1_valid_d;
  rdsm_pkg::rdsm_in_t  s1_q;

  // result register stage
  logic                out_valid_q, out_valid_d;
  rdsm_pkg::rdsm_out_t out_q;

  // NFA state: bit k = first k tokens consumed
  logic [MAX_TOKENS:0] active_q, active_d;
  rdsm_pkg::rdsm_out_t step_res;

  logic in_accept;
  logic out_free;
  logic s1_fire;

  assign cfg_ready_o = 1'b1;

  rdsm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i & cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  rdsm_nfa_step #(
    .MAX_TOKENS (MAX_TOKENS)
  ) u_step (
    .cfg_i    (cfg),
    .item_i   (s1_q),
    .active_i (active_q),
    .active_o (active_d),
    .result_o (step_res)
  );

  // Handshake: the result register frees up when empty or when taken this
  // cycle; the input stage moves on into it and commits the new state.
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign s1_fire    = s1_valid_q & out_free;
  assign in_stall_o = s1_valid_q & ~out_free;
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign s1_valid_d  = in_accept | (s1_valid_q & ~s1_fire);
  assign out_valid_d = s1_fire | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      active_q    <= (MAX_TOKENS + 1)'(1);
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        active_q <= active_d;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= in_data_i;
    end
    if (s1_fire) begin
      out_q <= step_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a full match always leaves the accepting position alive
  `RDSM_ASSERT(a_match_alive, clk_i, rst_ni, out_valid_q |-> (!out_q.matched || out_q.alive))
  // restart always leaves position zero active
  `RDSM_ASSERT(a_restart_alive, clk_i, rst_ni, (s1_fire && s1_q.kind == rdsm_pkg::KindRestart) |=> out_q.alive)
  // a request leaving the input stage lands in the result register
  `RDSM_ASSERT(a_fire_lands, clk_i, rst_ni, s1_fire |=> out_valid_q)
  // back-pressure only when both stages are occupied
  `RDSM_ASSERT_ALWAYS(a_stall_full, clk_i, in_stall_o |-> (s1_valid_q && out_valid_q))

endmodule
